>>> hw/rtl/bmpc_pkg.sv
`timescale 1ns / 1ps
// shared types, register indexes and pixel helpers for the bmp pixel converter
package bmpc_pkg;

	localparam int DIM_W = 13;
	localparam int CFG_IDX_W = 2;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

	localparam logic DIR_TO_555 = 1'b0;
	localparam logic DIR_TO_888 = 1'b1;

	// one completed pixel plus the row padding that follows it
	typedef struct packed {
		logic dir;
		logic [7:0] byte_lo;
		logic [7:0] byte_hi;
		logic [7:0] byte_last;
		logic [1:0] pad;
		logic img_end;
	} job_t;

	// c * 255 / 31 through a scaled reciprocal, exact for 5-bit c
	function automatic logic [7:0] expand5(input logic [4:0] c);
		logic [28:0] p;
		p = 29'(c) * 29'd255 * 29'd33826;
		return p[27:20];
	endfunction

endpackage

>>> hw/rtl/bmp_rgb_pixel_stream_converter_top.sv
`timescale 1ns / 1ps
// top level of the bmp pixel stream converter: configuration registers and the two ends
// Converts the pixel bytes of a bottom-up BMP raster between BGR888 and RGB555, one pixel
// per request. Source row padding is dropped and zero padding is added after each output
// row. The front end takes one byte per cycle while its two-entry request queue has room; each
// completed pixel becomes one request, and the back end sends one output byte per cycle while
// the output is not stalled (2 pixel bytes to RGB555, 3 to BGR888, plus up to 3 padding bytes
// at a row end). Toward BGR888 the back end's single output port sets the sustained rate.
// A pixel's bytes pass through the queue slot, the back end's job register and the output
// register. The user must see that configuration is written only while the stream is idle;
// the block itself does not enforce it.
module bmp_rgb_pixel_stream_converter_top import bmpc_pkg::*; #(
	parameter int MAX_WIDTH = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic [7:0] data_byte,
	output logic out_valid,
	input  logic out_stall,
	output logic [7:0] out_byte,
	output logic last_of_run,
	output logic end_of_image
);

	logic dir_q;
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;

	logic q_full;
	logic push;
	job_t push_job;
	logic q_valid;
	job_t q_job;
	logic pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= DIR_TO_555;
			width_q <= DIM_W'(1);
			height_q <= DIM_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DIRECTION: dir_q <= cfg_data[0];
				REG_WIDTH: width_q <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	bmpc_front #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.dir(dir_q),
		.img_w(width_q),
		.img_h(height_q),
		.q_full(q_full),
		.push(push),
		.job(push_job)
	);

	bmpc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_job(push_job),
		.full(q_full),
		.q_valid(q_valid),
		.q_job(q_job),
		.pop(pop)
	);

	bmpc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_job(q_job),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.last_of_run(last_of_run),
		.end_of_image(end_of_image)
	);

endmodule

>>> hw/rtl/bmpc_front.sv
`timescale 1ns / 1ps
// front end: takes source bytes, drops source padding, tracks row and image position
module bmpc_front import bmpc_pkg::*; #(
	parameter int MAX_WIDTH = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [7:0] data_byte,
	input  logic dir,
	input  logic [DIM_W-1:0] img_w,
	input  logic [DIM_W-1:0] img_h,
	input  logic q_full,
	output logic push,
	output job_t job
);

	localparam int COL_W = (MAX_WIDTH > 8192) ? DIM_W : ((MAX_WIDTH < 2) ? 1 : $clog2(MAX_WIDTH));
	localparam int ROW_W = (MAX_HEIGHT > 8192) ? DIM_W :
		((MAX_HEIGHT < 2) ? 1 : $clog2(MAX_HEIGHT));
	localparam logic [16:0] MAX_W_L = 17'(MAX_WIDTH);
	localparam logic [16:0] MAX_H_L = 17'(MAX_HEIGHT);

	logic [15:0] held_q;
	logic [1:0] phase_q;
	logic [1:0] pad_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	logic accept;
	logic complete;
	logic [1:0] bpp;
	logic [DIM_W-1:0] w_c;
	logic [DIM_W-1:0] h_c;
	logic [DIM_W:0] col_next;
	logic [DIM_W:0] row_next;
	logic row_end;
	logic img_last;
	logic [1:0] out_pad;
	logic [1:0] src_pad;

	assign in_stall = q_full;
	assign accept = in_valid && !q_full;

	always_comb begin
		if (img_w == '0) begin
			w_c = DIM_W'(1);
		end else if ({4'b0, img_w} > MAX_W_L) begin
			w_c = MAX_W_L[DIM_W-1:0];
		end else begin
			w_c = img_w;
		end
		if (img_h == '0) begin
			h_c = DIM_W'(1);
		end else if ({4'b0, img_h} > MAX_H_L) begin
			h_c = MAX_H_L[DIM_W-1:0];
		end else begin
			h_c = img_h;
		end
	end

	assign bpp = (dir == DIR_TO_888) ? 2'd2 : 2'd3;
	assign complete = (pad_q == 2'd0) && ({1'b0, phase_q} + 3'd1 >= {1'b0, bpp});
	assign col_next = (DIM_W+1)'(col_q) + (DIM_W+1)'(1);
	assign row_next = (DIM_W+1)'(row_q) + (DIM_W+1)'(1);
	assign row_end = col_next >= {1'b0, w_c};
	assign img_last = row_next >= {1'b0, h_c};

	// 3*w-byte rows pad by w[1:0] bytes, 2*w-byte rows pad by two when w is odd
	always_comb begin
		if (dir == DIR_TO_888) begin
			out_pad = w_c[1:0];
			src_pad = w_c[0] ? 2'd2 : 2'd0;
		end else begin
			out_pad = w_c[0] ? 2'd2 : 2'd0;
			src_pad = w_c[1:0];
		end
	end

	assign push = accept && complete;

	always_comb begin
		job.dir = dir;
		job.byte_lo = held_q[7:0];
		job.byte_hi = held_q[15:8];
		job.byte_last = data_byte;
		job.pad = row_end ? out_pad : 2'd0;
		job.img_end = row_end && img_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			phase_q <= '0;
			pad_q <= '0;
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (pad_q != 2'd0) begin
				pad_q <= pad_q - 2'd1;
			end else if (!complete) begin
				if (phase_q == 2'd0) begin
					held_q <= {8'h00, data_byte};
				end else begin
					held_q <= {data_byte, held_q[7:0]};
				end
				phase_q <= phase_q + 2'd1;
			end else begin
				phase_q <= '0;
				held_q <= '0;
				if (row_end) begin
					col_q <= '0;
					pad_q <= src_pad;
					row_q <= img_last ? '0 : row_next[ROW_W-1:0];
				end else begin
					col_q <= col_next[COL_W-1:0];
				end
			end
		end
	end

endmodule

>>> hw/rtl/bmpc_queue.sv
`timescale 1ns / 1ps
// short request queue between the front and back ends
module bmpc_queue import bmpc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	output logic q_valid,
	output job_t q_job,
	input  logic pop
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = count_q == CNT_W'(QUEUE_DEPTH);
	assign q_valid = count_q != '0;
	assign q_job = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && q_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

>>> hw/rtl/bmpc_back.sv
`timescale 1ns / 1ps
// back end: converts one pixel request and streams its bytes through the output register
module bmpc_back import bmpc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	input  job_t q_job,
	output logic pop,
	output logic out_valid,
	input  logic out_stall,
	output logic [7:0] out_byte,
	output logic last_of_run,
	output logic end_of_image
);

	job_t job_q;
	logic busy_q;
	logic [2:0] idx_q;
	logic out_valid_q;
	logic [7:0] out_byte_q;
	logic last_q;
	logic eoi_q;

	logic [15:0] pix555;
	logic [15:0] v;
	logic [7:0] pix_byte [3];
	logic [2:0] npix;
	logic [2:0] total;
	logic [7:0] sel_byte;
	logic at_last;
	logic advance;
	logic load;

	assign v = {job_q.byte_last, job_q.byte_lo};
	assign pix555 = {1'b0, job_q.byte_last[7:3], job_q.byte_hi[7:3], job_q.byte_lo[7:3]};

	always_comb begin
		if (job_q.dir == DIR_TO_888) begin
			pix_byte[0] = expand5(v[4:0]);
			pix_byte[1] = expand5(v[9:5]);
			pix_byte[2] = expand5(v[14:10]);
			npix = 3'd3;
		end else begin
			pix_byte[0] = pix555[7:0];
			pix_byte[1] = pix555[15:8];
			pix_byte[2] = 8'h00;
			npix = 3'd2;
		end
	end

	assign total = npix + {1'b0, job_q.pad};
	// bytes past the pixel are zero row padding
	assign sel_byte = (idx_q < npix) ? pix_byte[idx_q[1:0]] : 8'h00;
	assign at_last = idx_q == total - 3'd1;

	assign advance = busy_q && (!out_valid_q || !out_stall);
	assign load = q_valid && (!busy_q || (advance && at_last));
	assign pop = load;

	always_ff @(posedge clk) begin
		if (load) begin
			job_q <= q_job;
		end
		if (advance) begin
			out_byte_q <= sel_byte;
			last_q <= at_last;
			eoi_q <= at_last && job_q.img_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				idx_q <= '0;
			end else if (advance) begin
				if (at_last) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 3'd1;
				end
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign last_of_run = last_q;
	assign end_of_image = eoi_q;

endmodule
